// ===== rtl/core/m3i_pkg.sv =====
// Shared constants for the 3x3 matrix inverse core.
package m3i_pkg;

   localparam int NUM_ELEMS = 9;
   localparam int MAT_DIM   = 3;

   typedef int idx_table_type [MAT_DIM];

   // Cyclic neighbors of a row or column index.
   localparam idx_table_type NEXT1 = '{1, 2, 0};
   localparam idx_table_type NEXT2 = '{2, 0, 1};

endpackage

// ===== rtl/core/m3i_channels.sv =====
// Valid/ready channel interfaces for the matrix and inverse beats.
interface m3i_req_if #(
   parameter int ELEMENT_WIDTH = 32
);
   logic                            valid;
   logic                            ready;
   logic signed [ELEMENT_WIDTH-1:0] m11, m12, m13;
   logic signed [ELEMENT_WIDTH-1:0] m21, m22, m23;
   logic signed [ELEMENT_WIDTH-1:0] m31, m32, m33;

   modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                   input ready);
   modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                   output ready);
endinterface

interface m3i_rsp_if #(
   parameter int ELEMENT_WIDTH = 32
);
   logic                            valid;
   logic                            ready;
   logic signed [ELEMENT_WIDTH-1:0] r11, r12, r13;
   logic signed [ELEMENT_WIDTH-1:0] r21, r22, r23;
   logic signed [ELEMENT_WIDTH-1:0] r31, r32, r33;
   logic                            singular;
   logic signed [ELEMENT_WIDTH-1:0] det_value;

   modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                   singular, det_value, input ready);
   modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                   singular, det_value, output ready);
endinterface

// ===== rtl/core/m3i_divider.sv =====
// Pipelined restoring divider: nine numerators over one shared denominator.
module m3i_divider
   import m3i_pkg::*;
#(
   parameter int ELEMENT_WIDTH = 32,
   parameter int REM_WIDTH     = 133
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [REM_WIDTH-1:0]            num     [NUM_ELEMS],
   input  logic                            neg     [NUM_ELEMS],
   input  logic [REM_WIDTH-1:0]            den,
   output logic signed [ELEMENT_WIDTH-1:0] quo     [NUM_ELEMS]
);

   localparam int E = ELEMENT_WIDTH;
   localparam logic [E-1:0] MAXV = {1'b0, {(E-1){1'b1}}};
   localparam logic [E-1:0] MINV = {1'b1, {(E-1){1'b0}}};

   logic [REM_WIDTH-1:0] rem_ff [E+1][NUM_ELEMS];
   logic [REM_WIDTH-1:0] rem_in [E+1][NUM_ELEMS];
   logic [E-1:0]         quo_ff [E+1][NUM_ELEMS];
   logic [E-1:0]         quo_in [E+1][NUM_ELEMS];
   logic                 ovf_ff [E+1][NUM_ELEMS];
   logic                 neg_ff [E+1][NUM_ELEMS];
   logic [REM_WIDTH-1:0] den_ff [E+1];
   logic [REM_WIDTH-1:0] dsh    [E+1];
   logic [E-1:0]         res_ff [NUM_ELEMS];
   logic [E-1:0]         res_in [NUM_ELEMS];

   always_comb begin
      for (int l = 0; l < NUM_ELEMS; l++) begin
         rem_in[0][l] = num[l];
         quo_in[0][l] = '0;
      end
      dsh[0] = den << E;
      for (int s = 1; s <= E; s++) begin
         dsh[s] = den_ff[s-1] << (E - s);
         for (int l = 0; l < NUM_ELEMS; l++) begin
            if (rem_ff[s-1][l] >= dsh[s]) begin
               rem_in[s][l] = rem_ff[s-1][l] - dsh[s];
               quo_in[s][l] = quo_ff[s-1][l] | (E'(1) << (E - s));
            end else begin
               rem_in[s][l] = rem_ff[s-1][l];
               quo_in[s][l] = quo_ff[s-1][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_ELEMS; l++) begin
         if (neg_ff[E][l]) begin
            if (ovf_ff[E][l] || (quo_ff[E][l][E-1] && (|quo_ff[E][l][E-2:0])))
               res_in[l] = MINV;
            else
               res_in[l] = E'(0) - quo_ff[E][l];
         end else begin
            if (ovf_ff[E][l] || quo_ff[E][l][E-1])
               res_in[l] = MAXV;
            else
               res_in[l] = quo_ff[E][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= den;
         for (int l = 0; l < NUM_ELEMS; l++) begin
            rem_ff[0][l] <= rem_in[0][l];
            quo_ff[0][l] <= quo_in[0][l];
            ovf_ff[0][l] <= num[l] >= dsh[0];
            neg_ff[0][l] <= neg[l];
         end
         for (int s = 1; s <= E; s++) begin
            den_ff[s] <= den_ff[s-1];
            for (int l = 0; l < NUM_ELEMS; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               quo_ff[s][l] <= quo_in[s][l];
               ovf_ff[s][l] <= ovf_ff[s-1][l];
               neg_ff[s][l] <= neg_ff[s-1][l];
            end
         end
         for (int l = 0; l < NUM_ELEMS; l++)
            res_ff[l] <= res_in[l];
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_ELEMS; l++)
         quo[l] = $signed(res_ff[l]);
   end

endmodule

// ===== rtl/core/matrix3_inverse_core.sv =====
// 3x3 fixed-point matrix inverse by adjugate and pipelined division.
// One matrix beat enters per cycle while the pipeline advances: eight stages
// form the cofactors, the determinant and the division operands, then the
// shared-denominator restoring divider resolves one quotient bit per stage
// for all nine elements. The whole pipeline advances together whenever the
// result register is empty or taken, so throughput is one matrix per cycle
// with the consumer ready.
module matrix3_inverse_core
   import m3i_pkg::*;
#(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   m3i_req_if.sink    req,
   m3i_rsp_if.source  rsp
);

   localparam int E    = ELEMENT_WIDTH;
   localparam int F    = FRACTION_BITS;
   localparam int PW   = 2 * E;
   localparam int CW   = 2 * E + 1;
   localparam int LPW  = 2 * E + 2;
   localparam int DW   = 3 * E + 3;
   localparam int AN   = CW + 2 * F;
   localparam int NW   = ((AN + 1 > DW) ? AN + 1 : DW) + 1;
   localparam int SW   = DW + 1 + E;
   localparam int RW   = (NW > SW) ? NW : SW;
   localparam int DIV_LAT = E + 2;
   localparam int TOT     = 8 + DIV_LAT;
   localparam logic [E-1:0]  MAXV = {1'b0, {(E-1){1'b1}}};
   localparam logic [E-1:0]  MINV = {1'b1, {(E-1){1'b0}}};
   localparam logic [DW:0]   LIM  = (DW+1)'(1) << (E - 1);
   localparam logic [DW:0]   HALF = (DW+1)'(1) << (2 * F - 1);

   logic adv;
   logic [TOT-1:0] vld_ff, vld_in;

   logic signed [E-1:0]   a_ff     [NUM_ELEMS];
   logic signed [E-1:0]   acol2_ff [MAT_DIM];
   logic signed [E-1:0]   acol3_ff [MAT_DIM];
   logic signed [PW-1:0]  p0_ff    [NUM_ELEMS];
   logic signed [PW-1:0]  p1_ff    [NUM_ELEMS];
   logic signed [CW-1:0]  cof3_ff  [NUM_ELEMS];
   logic signed [CW-1:0]  cof4_ff  [NUM_ELEMS];
   logic signed [CW-1:0]  cof5_ff  [NUM_ELEMS];
   logic signed [CW-1:0]  cof6_ff  [NUM_ELEMS];
   logic signed [LPW-1:0] lo_ff    [MAT_DIM];
   logic signed [LPW-1:0] hi_ff    [MAT_DIM];
   logic signed [DW-1:0]  t_ff     [MAT_DIM];
   logic signed [DW-1:0]  det_ff;
   logic [DW-1:0]         dmag_ff;
   logic                  dneg_ff;
   logic                  sing7_ff;
   logic [AN-1:0]         nmag_ff  [NUM_ELEMS];
   logic                  nneg_ff  [NUM_ELEMS];
   logic [RW-1:0]         num_ff   [NUM_ELEMS];
   logic                  qneg_ff  [NUM_ELEMS];
   logic [RW-1:0]         den_ff;
   logic                  sing8_ff;
   logic [E-1:0]          detv8_ff;
   logic                  sing_dl_ff [DIV_LAT];
   logic [E-1:0]          detv_dl_ff [DIV_LAT];

   logic signed [E-1:0]   a_in [NUM_ELEMS];
   logic [CW-1:0]         cabs [NUM_ELEMS];
   logic [DW:0]           dq;
   logic [E-1:0]          detv_in;
   logic signed [E-1:0]   quo [NUM_ELEMS];
   logic                  sing_out;

   assign adv       = !vld_ff[TOT-1] || rsp.ready;
   assign req.ready = adv;

   always_comb begin
      vld_in    = vld_ff << 1;
      vld_in[0] = req.valid;
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (adv)
         vld_ff <= vld_in;
   end

   always_comb begin
      a_in[0] = req.m11; a_in[1] = req.m12; a_in[2] = req.m13;
      a_in[3] = req.m21; a_in[4] = req.m22; a_in[5] = req.m23;
      a_in[6] = req.m31; a_in[7] = req.m32; a_in[8] = req.m33;
   end

   always_comb begin
      for (int l = 0; l < NUM_ELEMS; l++)
         cabs[l] = cof6_ff[l][CW-1] ? CW'(-cof6_ff[l]) : CW'(cof6_ff[l]);
      dq = ({1'b0, dmag_ff} + HALF) >> (2 * F);
      if (dneg_ff) begin
         if (dq > LIM)
            detv_in = MINV;
         else
            detv_in = E'(0) - dq[E-1:0];
      end else begin
         if (dq >= LIM)
            detv_in = MAXV;
         else
            detv_in = dq[E-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NUM_ELEMS; l++)
            a_ff[l] <= a_in[l];
         for (int i = 0; i < MAT_DIM; i++) begin
            acol2_ff[i] <= a_ff[i*MAT_DIM];
            acol3_ff[i] <= acol2_ff[i];
            for (int j = 0; j < MAT_DIM; j++) begin
               p0_ff[i*MAT_DIM+j] <= PW'(a_ff[NEXT1[i]*MAT_DIM+NEXT1[j]])
                                   * PW'(a_ff[NEXT2[i]*MAT_DIM+NEXT2[j]]);
               p1_ff[i*MAT_DIM+j] <= PW'(a_ff[NEXT1[i]*MAT_DIM+NEXT2[j]])
                                   * PW'(a_ff[NEXT2[i]*MAT_DIM+NEXT1[j]]);
            end
         end
         for (int l = 0; l < NUM_ELEMS; l++) begin
            cof3_ff[l] <= CW'(p0_ff[l]) - CW'(p1_ff[l]);
            cof4_ff[l] <= cof3_ff[l];
            cof5_ff[l] <= cof4_ff[l];
            cof6_ff[l] <= cof5_ff[l];
         end
         for (int i = 0; i < MAT_DIM; i++) begin
            lo_ff[i] <= LPW'(acol3_ff[i])
                      * LPW'($signed({1'b0, cof3_ff[i*MAT_DIM][E-1:0]}));
            hi_ff[i] <= LPW'(acol3_ff[i])
                      * LPW'($signed(cof3_ff[i*MAT_DIM][CW-1:E]));
            t_ff[i]  <= (DW'(hi_ff[i]) <<< E) + DW'(lo_ff[i]);
         end
         det_ff <= t_ff[0] + t_ff[1] + t_ff[2];

         dmag_ff  <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
         dneg_ff  <= det_ff[DW-1];
         sing7_ff <= (det_ff == '0);
         for (int i = 0; i < MAT_DIM; i++) begin
            for (int j = 0; j < MAT_DIM; j++) begin
               nmag_ff[i*MAT_DIM+j] <= AN'(cabs[j*MAT_DIM+i]) << (2 * F);
               nneg_ff[i*MAT_DIM+j] <= cof6_ff[j*MAT_DIM+i][CW-1];
            end
         end

         for (int l = 0; l < NUM_ELEMS; l++) begin
            num_ff[l]  <= (RW'(nmag_ff[l]) << 1) + RW'(dmag_ff);
            qneg_ff[l] <= nneg_ff[l] ^ dneg_ff;
         end
         den_ff   <= RW'(dmag_ff) << 1;
         sing8_ff <= sing7_ff;
         detv8_ff <= detv_in;

         sing_dl_ff[0] <= sing8_ff;
         detv_dl_ff[0] <= detv8_ff;
         for (int s = 1; s < DIV_LAT; s++) begin
            sing_dl_ff[s] <= sing_dl_ff[s-1];
            detv_dl_ff[s] <= detv_dl_ff[s-1];
         end
      end
   end

   m3i_divider #(
      .ELEMENT_WIDTH (E),
      .REM_WIDTH     (RW)
   ) u_divider (
      .clock (clock),
      .en    (adv),
      .num   (num_ff),
      .neg   (qneg_ff),
      .den   (den_ff),
      .quo   (quo)
   );

   assign sing_out      = sing_dl_ff[DIV_LAT-1];
   assign rsp.valid     = vld_ff[TOT-1];
   assign rsp.singular  = sing_out;
   assign rsp.det_value = $signed(detv_dl_ff[DIV_LAT-1]);
   assign rsp.r11 = sing_out ? '0 : quo[0];
   assign rsp.r12 = sing_out ? '0 : quo[1];
   assign rsp.r13 = sing_out ? '0 : quo[2];
   assign rsp.r21 = sing_out ? '0 : quo[3];
   assign rsp.r22 = sing_out ? '0 : quo[4];
   assign rsp.r23 = sing_out ? '0 : quo[5];
   assign rsp.r31 = sing_out ? '0 : quo[6];
   assign rsp.r32 = sing_out ? '0 : quo[7];
   assign rsp.r33 = sing_out ? '0 : quo[8];

`ifndef ASSERT_OFF
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req.ready |=> $stable(vld_ff))
      else $error("pipeline valids moved during a stall");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("input ready disagrees with output register state");

   a_singular_det: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.singular |-> rsp.det_value == '0 && rsp.r11 == '0)
      else $error("singular beat carries nonzero values");
`endif

endmodule

// ===== bench/tb_matrix3_inverse_core.sv =====
// Self-checking testbench for the 3x3 fixed-point matrix inverse core.
`timescale 1ns / 100ps

module tb_matrix3_inverse_core;
   import m3i_pkg::*;

   localparam int EW          = 32;
   localparam int FB          = 16;
   localparam int NUM_RANDOM  = 600;
   localparam int STALL_AT    = 120;
   localparam int STALL_LEN   = 300;
   localparam int DRAIN_AT    = 400;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 80;

   typedef logic signed [EW-1:0] elem_t;
   typedef logic signed [199:0]  wide_t;
   typedef logic [199:0]         mag_t;

   typedef struct packed {
      elem_t m11, m12, m13, m21, m22, m23, m31, m32, m33;
   } matrix_t;

   typedef struct packed {
      elem_t r11, r12, r13, r21, r22, r23, r31, r32, r33;
      logic  singular;
      elem_t det_value;
   } inverse_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   m3i_req_if #(.ELEMENT_WIDTH(EW)) req_ch ();
   m3i_rsp_if #(.ELEMENT_WIDTH(EW)) rsp_ch ();

   matrix3_inverse_core #(.ELEMENT_WIDTH(EW), .FRACTION_BITS(FB)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #5 clock = ~clock;

   matrix_t  pending_mats[$];
   inverse_t expected_inverses[$];
   int       mats_sent;
   int       inverses_seen;
   int       mismatch_count;
   int       idle_cycles;
   bit       stimulus_done;
   bit       timed_out;

   // round half away from zero, saturate to the element range
   function automatic elem_t div_round_sat(wide_t num, wide_t den);
      logic  neg;
      mag_t  a, b, q, lim;
      neg = num[199] ^ den[199];
      a   = num[199] ? mag_t'(-num) : mag_t'(num);
      b   = den[199] ? mag_t'(-den) : mag_t'(den);
      q   = ((a << 1) + b) / (b << 1);
      lim = mag_t'(1) << (EW - 1);
      if (neg) begin
         if (q > lim) return {1'b1, {(EW-1){1'b0}}};
         return elem_t'(-q);
      end
      if (q >= lim) return {1'b0, {(EW-1){1'b1}}};
      return elem_t'(q);
   endfunction

   function automatic inverse_t invert_matrix(matrix_t m);
      wide_t    a[3][3];
      wide_t    cof[3][3];
      wide_t    det;
      elem_t    r[3][3];
      inverse_t res;
      a[0][0] = m.m11; a[0][1] = m.m12; a[0][2] = m.m13;
      a[1][0] = m.m21; a[1][1] = m.m22; a[1][2] = m.m23;
      a[2][0] = m.m31; a[2][1] = m.m32; a[2][2] = m.m33;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                      - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
         end
      end
      det = a[0][0] * cof[0][0] + a[1][0] * cof[1][0] + a[2][0] * cof[2][0];
      res = '0;
      if (det == 0) begin
         res.singular = 1'b1;
         return res;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            r[i][j] = div_round_sat(cof[j][i] <<< (2 * FB), det);
      res.r11 = r[0][0]; res.r12 = r[0][1]; res.r13 = r[0][2];
      res.r21 = r[1][0]; res.r22 = r[1][1]; res.r23 = r[1][2];
      res.r31 = r[2][0]; res.r32 = r[2][1]; res.r33 = r[2][2];
      res.det_value = div_round_sat(det, wide_t'(1) <<< (2 * FB));
      return res;
   endfunction

   function automatic elem_t random_element(int mode);
      case (mode)
         0: return elem_t'($urandom);
         1: return elem_t'(int'($urandom_range(32'h0006_0000)) - 32'sh0003_0000);
         2: return elem_t'(int'($urandom_range(64)) - 32);
         default: return elem_t'($signed($urandom) >>> $urandom_range(31));
      endcase
   endfunction

   function automatic matrix_t random_matrix();
      matrix_t m;
      int      mode;
      int      kind;
      mode = $urandom_range(3);
      m = {random_element(mode), random_element(mode), random_element(mode),
           random_element(mode), random_element(mode), random_element(mode),
           random_element(mode), random_element(mode), random_element(mode)};
      kind = $urandom_range(9);
      case (kind)
         0: begin
            m.m31 = m.m11; m.m32 = m.m12; m.m33 = m.m13;
         end
         1: begin
            m.m12 = m.m11; m.m22 = m.m21; m.m32 = m.m31;
         end
         2: begin
            m.m21 = '0; m.m22 = '0; m.m23 = '0;
         end
         3: begin
            m.m12 = '0; m.m13 = '0; m.m21 = '0;
            m.m23 = '0; m.m31 = '0; m.m32 = '0;
         end
         default: ;
      endcase
      return m;
   endfunction

   function automatic matrix_t diag_matrix(elem_t d1, elem_t d2, elem_t d3);
      matrix_t m;
      m = '0;
      m.m11 = d1; m.m22 = d2; m.m33 = d3;
      return m;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      localparam elem_t ONE  = 32'sh0001_0000;
      localparam elem_t EMAX = 32'sh7FFF_FFFF;
      localparam elem_t EMIN = 32'sh8000_0000;
      matrix_t m;
      req_ch.valid = 1'b0;
      req_ch.m11 = '0; req_ch.m12 = '0; req_ch.m13 = '0;
      req_ch.m21 = '0; req_ch.m22 = '0; req_ch.m23 = '0;
      req_ch.m31 = '0; req_ch.m32 = '0; req_ch.m33 = '0;
      rsp_ch.ready = 1'b0;

      pending_mats.push_back(diag_matrix(ONE, ONE, ONE));
      pending_mats.push_back('0);
      pending_mats.push_back({9{EMAX}});
      pending_mats.push_back({9{EMIN}});
      pending_mats.push_back(diag_matrix(EMAX, EMAX, EMAX));
      pending_mats.push_back(diag_matrix(EMIN, EMIN, EMIN));
      pending_mats.push_back(diag_matrix(EMIN, EMAX, EMIN));
      pending_mats.push_back(diag_matrix(32'sd1, 32'sd1, 32'sd1));
      pending_mats.push_back(diag_matrix(-32'sd1, 32'sd1, 32'sd1));
      pending_mats.push_back(diag_matrix(32'sh0002_0000, ONE, -ONE));
      pending_mats.push_back(diag_matrix(32'sh0003_0000, 32'sh0007_0000, ONE));
      pending_mats.push_back(diag_matrix(32'sd2, EMAX, 32'sd3));
      pending_mats.push_back(diag_matrix(32'sh0000_8000, ONE, ONE));
      m = {ONE, 32'sh0002_0000, 32'sh0003_0000,
           32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000,
           32'sh0007_0000, 32'sh0008_0000, 32'sh0009_0000};
      pending_mats.push_back(m);
      m = {32'sh0002_0000, -ONE, 32'sd0, -ONE, 32'sh0002_0000, -ONE,
           32'sd0, -ONE, 32'sh0002_0000};
      pending_mats.push_back(m);
      m = {EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMIN};
      pending_mats.push_back(m);
      m = {32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE, ONE, 32'sd0, 32'sd0};
      pending_mats.push_back(m);
      m = {32'sd7, -32'sd3, 32'sd5, 32'sd1, 32'sd9, -32'sd2, 32'sd4, 32'sd6, 32'sd8};
      pending_mats.push_back(m);
      for (int k = 0; k < NUM_RANDOM; k++)
         pending_mats.push_back(random_matrix());

      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   int  req_gap;
   bit  drained;

   always @(posedge clock) begin
      matrix_t next_mat;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap      <= 0;
         drained      <= 1'b0;
         mats_sent    <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_inverses.push_back(invert_matrix({req_ch.m11, req_ch.m12, req_ch.m13,
               req_ch.m21, req_ch.m22, req_ch.m23, req_ch.m31, req_ch.m32, req_ch.m33}));
            mats_sent <= mats_sent + 1;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the beat until taken
         end else if (mats_sent >= DRAIN_AT && !drained) begin
            req_ch.valid <= 1'b0;
            if (expected_inverses.size() == 0 && !(req_ch.valid && req_ch.ready))
               drained <= 1'b1;
         end else if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap      <= req_gap - 1;
         end else if (pending_mats.size() > 0) begin
            next_mat = pending_mats.pop_front();
            req_ch.valid <= 1'b1;
            {req_ch.m11, req_ch.m12, req_ch.m13, req_ch.m21, req_ch.m22,
             req_ch.m23, req_ch.m31, req_ch.m32, req_ch.m33} <= next_mat;
            req_gap <= pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   int rsp_gap;
   int stall_left;
   bit stalled_once;

   always @(posedge clock) begin
      inverse_t got, want;
      if (reset) begin
         rsp_ch.ready  <= 1'b0;
         rsp_gap       <= 0;
         stall_left    <= 0;
         stalled_once  <= 1'b0;
         inverses_seen <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.r11, rsp_ch.r12, rsp_ch.r13, rsp_ch.r21, rsp_ch.r22,
                   rsp_ch.r23, rsp_ch.r31, rsp_ch.r32, rsp_ch.r33,
                   rsp_ch.singular, rsp_ch.det_value};
            inverses_seen <= inverses_seen + 1;
            if (expected_inverses.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected beat %0d: %h", inverses_seen, got);
            end else begin
               want = expected_inverses.pop_front();
               if (got !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display("mismatch beat %0d", inverses_seen);
                     $display("  exp r=%h %h %h %h %h %h %h %h %h sing=%b det=%h",
                        want.r11, want.r12, want.r13, want.r21, want.r22, want.r23,
                        want.r31, want.r32, want.r33, want.singular, want.det_value);
                     $display("  got r=%h %h %h %h %h %h %h %h %h sing=%b det=%h",
                        got.r11, got.r12, got.r13, got.r21, got.r22, got.r23,
                        got.r31, got.r32, got.r33, got.singular, got.det_value);
                  end
               end
            end
         end
         if (!stalled_once && inverses_seen >= STALL_AT) begin
            stalled_once <= 1'b1;
            stall_left   <= STALL_LEN;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap      <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_gap      <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      mismatch_count = 0;
      idle_cycles    = 0;
      stimulus_done  = 1'b0;
      timed_out      = 1'b0;
      fork
         begin
            while (!(stimulus_done && expected_inverses.size() == 0))
               @(posedge clock);
            repeat (TAIL_CYCLES) @(posedge clock);
         end
         begin
            wait (idle_cycles >= IDLE_LIMIT);
            timed_out = 1'b1;
         end
      join_any
      if (!timed_out && mismatch_count == 0 && expected_inverses.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
